/* sv/bfa_pkg.sv */
// shared types, constants and codes of the best-fit block allocator
package bfa_pkg;

   // default sizing
   localparam int NUM_BLOCKS_DEF  = 1024;
   localparam int BLOCK_BYTES_DEF = 1024;
   localparam int FREE_CAP_DEF    = 2048;
   localparam int ALLOC_CAP_DEF   = 1024;

   // result status codes
   typedef enum logic [2:0] {
      ST_ALLOC   = 3'd0,
      ST_NOFIT   = 3'd1,
      ST_REL     = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   // sorted table operations
   typedef enum logic [2:0] {
      TOP_NONE,
      TOP_APPEND,
      TOP_FIND_GE,
      TOP_FIND_EQ,
      TOP_FIND_POS,
      TOP_DEL,
      TOP_INS
   } tbl_op_type;

   // controller states
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_A_FIT,
      S_A_FDEL,
      S_A_FPOS,
      S_A_FINS,
      S_A_APOS,
      S_A_AINS,
      S_R_FIND,
      S_R_ADEL,
      S_R_FPOS,
      S_R_FINS,
      S_DONE
   } state_type;

   // input beat
   typedef struct packed {
      logic        command;
      logic [15:0] request_id;
      logic [10:0] req_bytes;
   } req_type;

   // result beat
   typedef struct packed {
      status_type  status;
      logic [9:0]  block_index;
      logic [10:0] byte_count;
      logic [15:0] echo_id;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      tbl_op_type f_op;
      logic       f_go;
      tbl_op_type a_op;
      logic       a_go;
      logic       latch;
      logic       load_free_hit;
      logic       load_alloc_hit;
      logic       res_set;
      status_type res_code;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic f_done;
      logic f_found;
      logic f_full;
      logic a_done;
      logic a_found;
      logic a_full;
      logic frag_zero;
      logic init_done;
      logic req_release;
   } ctl_sts_type;

endpackage

/* sv/best_fit_block_allocator_unit.sv */
// top level of the best-fit block allocator
//
//  channel  ports                      handshake
//  -------  -------------------------  -----------------------------------
//  request  start, busy, req_beat      taken when start is high, busy low
//  result   rsp_strobe, rsp_beat       one cycle, taken when strobe high
//
// After reset the free table is filled one entry a cycle, min(NUM_BLOCKS,
// FREE_CAP) entries, with busy high. Each table is a one-read one-write
// memory walked one entry at a time: an allocate with a remainder runs a fit
// search and removal, then a re-file search and shift in the free table, then
// a search and shift in the record table; an exact fit skips the re-file. A
// release runs a record search and removal, then a free search and shift. One
// beat is in work at a time. The result is shown for one cycle; the receiver
// cannot stall it.
module best_fit_block_allocator_unit #(
   parameter int NUM_BLOCKS  = bfa_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = bfa_pkg::BLOCK_BYTES_DEF,
   parameter int FREE_CAP    = bfa_pkg::FREE_CAP_DEF,
   parameter int ALLOC_CAP   = bfa_pkg::ALLOC_CAP_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bfa_pkg::req_type req_beat,
   output logic             rsp_strobe,
   output bfa_pkg::rsp_type rsp_beat
);
   import bfa_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencing
   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .sts        (sts),
      .cmd        (cmd)
   );

   // tables and registers
   bfa_datapath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .FREE_CAP    (FREE_CAP),
      .ALLOC_CAP   (ALLOC_CAP)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_beat),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_beat)
   );

endmodule

/* sv/bfa_table.sv */
// ordered table in a one-read one-write memory with a search and shift sequencer
module bfa_table #(
   parameter int DEPTH = 4,
   parameter int KW    = 8,
   parameter int DW    = 8,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  bfa_pkg::tbl_op_type op,
   input  logic                go,
   input  logic [KW-1:0]       key_in,
   input  logic [DW-1:0]       data_in,
   output logic [CW-1:0]       count,
   output logic                found,
   output logic                done,
   output logic [KW-1:0]       ent_key,
   output logic [DW-1:0]       ent_data
);
   import bfa_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [KW+DW-1:0] mem [DEPTH];
   logic [KW+DW-1:0] rd_ff;
   logic [KW+DW-1:0] ent_ff, ent_in;
   logic [KW+DW-1:0] wdata;
   logic [AW-1:0]    waddr, raddr;
   logic             we;

   logic             act_ff, act_in;
   tbl_op_type       op_ff, op_in;
   logic             ph_ff, ph_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             found_ff, found_in;
   logic             done_ff, done_in;
   logic [KW-1:0]    key_ff, key_in_r;
   logic [DW-1:0]    data_ff, data_in_r;

   logic [CW-1:0]    ptr_inc, ptr_dec;
   logic [KW-1:0]    rd_key;
   logic             hit;

   assign ptr_inc = ptr_ff + 1'b1;
   assign ptr_dec = ptr_ff - 1'b1;
   assign rd_key  = rd_ff[KW+DW-1:DW];

   // match test of the entry just read
   always_comb begin
      case (op_ff)
         TOP_FIND_GE:  hit = (rd_key >= key_ff);
         TOP_FIND_EQ:  hit = (rd_key == key_ff);
         TOP_FIND_POS: hit = (ptr_ff == '0) ? (key_ff < rd_key) : (rd_key >= key_ff);
         default:      hit = 1'b0;
      endcase
   end

   // sequencer: walks one entry at a time, a read phase then a compare or write phase
   always_comb begin
      act_in    = act_ff;
      op_in     = op_ff;
      ph_in     = ph_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      found_in  = found_ff;
      ent_in    = ent_ff;
      key_in_r  = key_ff;
      data_in_r = data_ff;
      done_in   = 1'b0;
      we        = 1'b0;
      waddr     = ptr_ff[AW-1:0];
      wdata     = rd_ff;
      raddr     = ptr_ff[AW-1:0];
      if (!act_ff) begin
         if (go) begin
            unique case (op)
               TOP_APPEND: begin
                  we      = 1'b1;
                  waddr   = cnt_ff[AW-1:0];
                  wdata   = {key_in, data_in};
                  cnt_in  = cnt_ff + 1'b1;
                  done_in = 1'b1;
               end
               TOP_FIND_GE, TOP_FIND_EQ, TOP_FIND_POS: begin
                  act_in = 1'b1;
                  op_in  = op;
                  ph_in  = 1'b0;
                  ptr_in = '0;
                  key_in_r = key_in;
               end
               TOP_DEL: begin
                  act_in = 1'b1;
                  op_in  = op;
                  ph_in  = 1'b0;
                  ptr_in = pos_ff;
               end
               TOP_INS: begin
                  act_in    = 1'b1;
                  op_in     = op;
                  ph_in     = 1'b0;
                  ptr_in    = cnt_ff;
                  key_in_r  = key_in;
                  data_in_r = data_in;
               end
               default: ;
            endcase
         end
      end else begin
         case (op_ff)
            TOP_FIND_GE, TOP_FIND_EQ, TOP_FIND_POS: begin
               if (!ph_ff) begin
                  if (ptr_ff == cnt_ff) begin
                     act_in   = 1'b0;
                     done_in  = 1'b1;
                     found_in = 1'b0;
                     pos_in   = cnt_ff;
                  end else begin
                     ph_in = 1'b1;
                  end
               end else if (hit) begin
                  act_in   = 1'b0;
                  done_in  = 1'b1;
                  found_in = 1'b1;
                  pos_in   = ptr_ff;
                  ent_in   = rd_ff;
               end else begin
                  ptr_in = ptr_inc;
                  ph_in  = 1'b0;
               end
            end
            TOP_DEL: begin
               if (!ph_ff) begin
                  if (ptr_inc >= cnt_ff) begin
                     act_in  = 1'b0;
                     done_in = 1'b1;
                     cnt_in  = cnt_ff - 1'b1;
                  end else begin
                     raddr = ptr_inc[AW-1:0];
                     ph_in = 1'b1;
                  end
               end else begin
                  we     = 1'b1;
                  ptr_in = ptr_inc;
                  ph_in  = 1'b0;
               end
            end
            TOP_INS: begin
               if (!ph_ff) begin
                  if (ptr_ff == pos_ff) begin
                     we      = 1'b1;
                     wdata   = {key_ff, data_ff};
                     cnt_in  = cnt_ff + 1'b1;
                     act_in  = 1'b0;
                     done_in = 1'b1;
                  end else begin
                     raddr = ptr_dec[AW-1:0];
                     ph_in = 1'b1;
                  end
               end else begin
                  we     = 1'b1;
                  ptr_in = ptr_dec;
                  ph_in  = 1'b0;
               end
            end
            default: act_in = 1'b0;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         ph_ff   <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         op_ff   <= TOP_NONE;
      end else begin
         act_ff  <= act_in;
         ph_ff   <= ph_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      ent_ff   <= ent_in;
      key_ff   <= key_in_r;
      data_ff  <= data_in_r;
   end

   // table memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   assign count    = cnt_ff;
   assign found    = found_ff;
   assign done     = done_ff;
   assign ent_key  = ent_ff[KW+DW-1:DW];
   assign ent_data = ent_ff[DW-1:0];

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("table count beyond depth");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      act_ff |-> ptr_ff <= cnt_ff) else $error("walk pointer beyond fill");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !act_ff) else $error("done while still walking");

endmodule

/* sv/bfa_datapath.sv */
// request, fragment and result registers around the free and record tables
module bfa_datapath #(
   parameter int NUM_BLOCKS  = bfa_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = bfa_pkg::BLOCK_BYTES_DEF,
   parameter int FREE_CAP    = bfa_pkg::FREE_CAP_DEF,
   parameter int ALLOC_CAP   = bfa_pkg::ALLOC_CAP_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bfa_pkg::req_type     req,
   input  bfa_pkg::ctl_cmd_type cmd,
   output bfa_pkg::ctl_sts_type sts,
   output bfa_pkg::rsp_type     rsp
);
   import bfa_pkg::*;

   localparam int BW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int SW0    = $clog2(BLOCK_BYTES + 1);
   localparam int SW     = (SW0 > 11) ? SW0 : 11;
   localparam int FCW    = $clog2(FREE_CAP + 1);
   localparam int ACW    = $clog2(ALLOC_CAP + 1);
   localparam int INIT_N = (NUM_BLOCKS < FREE_CAP) ? NUM_BLOCKS : FREE_CAP;

   logic [15:0]   id_ff;
   logic [10:0]   bytes_ff;
   logic [SW-1:0] frag_size_ff;
   logic [BW-1:0] frag_blk_ff;
   logic [BW-1:0] rblk_ff;
   logic [SW-1:0] rbytes_ff;
   status_type    rstat_ff;

   logic [SW-1:0]    f_key;
   logic [BW-1:0]    f_data;
   logic [FCW-1:0]   f_cnt;
   logic             f_found, f_done;
   logic [SW-1:0]    f_ent_key;
   logic [BW-1:0]    f_ent_data;
   logic [ACW-1:0]   a_cnt;
   logic             a_found, a_done;
   logic [15:0]      a_ent_key;
   logic [BW+SW-1:0] a_ent_data;

   // free table operands
   always_comb begin
      case (cmd.f_op)
         TOP_APPEND: begin
            f_key  = SW'(BLOCK_BYTES);
            f_data = (f_cnt == '0) ? '0 : (BW'(NUM_BLOCKS) - BW'(f_cnt));
         end
         TOP_FIND_GE: begin
            f_key  = SW'(bytes_ff);
            f_data = frag_blk_ff;
         end
         default: begin
            f_key  = frag_size_ff;
            f_data = frag_blk_ff;
         end
      endcase
   end

   bfa_table #(.DEPTH(FREE_CAP), .KW(SW), .DW(BW)) u_free (
      .clock    (clock),
      .reset    (reset),
      .op       (cmd.f_op),
      .go       (cmd.f_go),
      .key_in   (f_key),
      .data_in  (f_data),
      .count    (f_cnt),
      .found    (f_found),
      .done     (f_done),
      .ent_key  (f_ent_key),
      .ent_data (f_ent_data)
   );

   bfa_table #(.DEPTH(ALLOC_CAP), .KW(16), .DW(BW + SW)) u_rec (
      .clock    (clock),
      .reset    (reset),
      .op       (cmd.a_op),
      .go       (cmd.a_go),
      .key_in   (id_ff),
      .data_in  ({rblk_ff, rbytes_ff}),
      .count    (a_cnt),
      .found    (a_found),
      .done     (a_done),
      .ent_key  (a_ent_key),
      .ent_data (a_ent_data)
   );

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         id_ff    <= req.request_id;
         bytes_ff <= req.req_bytes;
      end
   end

   // fragment and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_free_hit) begin
         rblk_ff      <= f_ent_data;
         rbytes_ff    <= SW'(bytes_ff);
         frag_blk_ff  <= f_ent_data;
         frag_size_ff <= f_ent_key - SW'(bytes_ff);
      end else if (cmd.load_alloc_hit) begin
         rblk_ff      <= a_ent_data[BW+SW-1:SW];
         rbytes_ff    <= a_ent_data[SW-1:0];
         frag_blk_ff  <= a_ent_data[BW+SW-1:SW];
         frag_size_ff <= a_ent_data[SW-1:0];
      end else if (cmd.res_set && cmd.res_code != ST_ALLOC && cmd.res_code != ST_REL) begin
         rblk_ff   <= '0;
         rbytes_ff <= '0;
      end
      if (cmd.res_set) begin
         rstat_ff <= cmd.res_code;
      end
   end

   // status toward the controller
   always_comb begin
      sts.f_done      = f_done;
      sts.f_found     = f_found;
      sts.f_full      = (f_cnt == FCW'(FREE_CAP));
      sts.a_done      = a_done;
      sts.a_found     = a_found;
      sts.a_full      = (a_cnt == ACW'(ALLOC_CAP));
      sts.frag_zero   = (frag_size_ff == '0);
      sts.init_done   = (f_cnt == FCW'(INIT_N));
      sts.req_release = req.command;
   end

   // result beat
   always_comb begin
      rsp.status      = rstat_ff;
      rsp.block_index = 10'(rblk_ff);
      rsp.byte_count  = rbytes_ff[10:0];
      rsp.echo_id     = id_ff;
   end

   a_free_fit: assert property (@(posedge clock) disable iff (reset)
      cmd.load_free_hit |-> f_ent_key >= SW'(bytes_ff))
      else $error("fragment smaller than request");
   a_rec_key: assert property (@(posedge clock) disable iff (reset)
      cmd.load_alloc_hit |-> a_ent_key == id_ff)
      else $error("record id does not match request");
   a_one_table: assert property (@(posedge clock) disable iff (reset)
      !(cmd.f_go && cmd.a_go)) else $error("both tables started together");

endmodule

/* sv/bfa_ctrl.sv */
// controller state machine that sequences table operations per request
module bfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   input  bfa_pkg::ctl_sts_type sts,
   output bfa_pkg::ctl_cmd_type cmd
);
   import bfa_pkg::*;

   state_type state_ff, state_in;
   logic      first_ff, first_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         first_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   assign first_in = (state_in != state_ff);

   // next state and commands
   always_comb begin
      state_in           = state_ff;
      cmd.f_op           = TOP_NONE;
      cmd.f_go           = 1'b0;
      cmd.a_op           = TOP_NONE;
      cmd.a_go           = 1'b0;
      cmd.latch          = 1'b0;
      cmd.load_free_hit  = 1'b0;
      cmd.load_alloc_hit = 1'b0;
      cmd.res_set        = 1'b0;
      cmd.res_code       = ST_ALLOC;
      rsp_strobe         = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            if (sts.init_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.f_op = TOP_APPEND;
               cmd.f_go = 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               if (sts.req_release) begin
                  state_in = S_R_FIND;
               end else if (sts.a_full) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = ST_FULL;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_A_FIT;
               end
            end
         end
         S_A_FIT: begin
            cmd.f_op = TOP_FIND_GE;
            cmd.f_go = first_ff;
            if (sts.f_done) begin
               if (sts.f_found) begin
                  cmd.load_free_hit = 1'b1;
                  state_in          = S_A_FDEL;
               end else begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = ST_NOFIT;
                  state_in     = S_DONE;
               end
            end
         end
         S_A_FDEL: begin
            cmd.f_op = TOP_DEL;
            cmd.f_go = first_ff;
            if (sts.f_done) begin
               state_in = sts.frag_zero ? S_A_APOS : S_A_FPOS;
            end
         end
         S_A_FPOS: begin
            cmd.f_op = TOP_FIND_POS;
            cmd.f_go = first_ff;
            if (sts.f_done) begin
               state_in = S_A_FINS;
            end
         end
         S_A_FINS: begin
            cmd.f_op = TOP_INS;
            cmd.f_go = first_ff;
            if (sts.f_done) begin
               state_in = S_A_APOS;
            end
         end
         S_A_APOS: begin
            cmd.a_op = TOP_FIND_POS;
            cmd.a_go = first_ff;
            if (sts.a_done) begin
               state_in = S_A_AINS;
            end
         end
         S_A_AINS: begin
            cmd.a_op = TOP_INS;
            cmd.a_go = first_ff;
            if (sts.a_done) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_ALLOC;
               state_in     = S_DONE;
            end
         end
         S_R_FIND: begin
            cmd.a_op = TOP_FIND_EQ;
            cmd.a_go = first_ff;
            if (sts.a_done) begin
               if (!sts.a_found) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = ST_UNKNOWN;
                  state_in     = S_DONE;
               end else if (sts.f_full) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = ST_FULL;
                  state_in     = S_DONE;
               end else begin
                  cmd.load_alloc_hit = 1'b1;
                  state_in           = S_R_ADEL;
               end
            end
         end
         S_R_ADEL: begin
            cmd.a_op = TOP_DEL;
            cmd.a_go = first_ff;
            if (sts.a_done) begin
               state_in = S_R_FPOS;
            end
         end
         S_R_FPOS: begin
            cmd.f_op = TOP_FIND_POS;
            cmd.f_go = first_ff;
            if (sts.f_done) begin
               state_in = S_R_FINS;
            end
         end
         S_R_FINS: begin
            cmd.f_op = TOP_INS;
            cmd.f_go = first_ff;
            if (sts.f_done) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_REL;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe longer than a cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("not idle after result");

endmodule
